// ===== hdl/quaternion_to_rotation_matrix_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the quaternion to rotation matrix unit
// Concurrent checks that are compiled in simulation and left out in synthesis.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_TO_ROTATION_MATRIX_UNIT_ASSERT_SVH
`define QUATERNION_TO_ROTATION_MATRIX_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define QRM_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("qrm check failed");

// The consequent must hold in the cycle after the antecedent.
`define QRM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("qrm check failed");

`else

`define QRM_ASSERT_SAME(label, ante, cons)
`define QRM_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== hdl/qrm_pkg.sv =====
// ----------------------------------------------------------------------------
// qrm_pkg
// Widths and constants of the quaternion to rotation matrix unit.
// ----------------------------------------------------------------------------
package qrm_pkg;

	localparam int CompW  = 16;           // input component width
	localparam int ProdW  = 32;           // one component product
	localparam int SumW   = 33;           // sum of four squares, up to 2^32
	localparam int NumW   = 34;           // signed entry numerator
	localparam int MagW   = 33;           // numerator magnitude
	localparam int DenW   = 34;           // divisor, twice the sum
	localparam int RemW   = 48;           // dividend and partial remainder
	localparam int QuoW   = 15;           // quotient, 0..16384
	localparam int EntW   = 16;           // output entry
	localparam int NumEnt = 9;            // matrix entries
	localparam int NumPrd = 10;           // distinct products
	localparam int FracW  = 15;           // dividend shift: 2 * 16384

	localparam logic [EntW-1:0] OneQ14 = 16'sd16384;

	// Product slots of the first stage.
	localparam int PWW = 0;
	localparam int PXX = 1;
	localparam int PYY = 2;
	localparam int PZZ = 3;
	localparam int PXY = 4;
	localparam int PWZ = 5;
	localparam int PXZ = 6;
	localparam int PWY = 7;
	localparam int PYZ = 8;
	localparam int PWX = 9;

	typedef logic signed [ProdW-1:0] prod_t;
	typedef logic signed [NumW-1:0]  num_t;
	typedef logic [RemW-1:0]         rem_t;
	typedef logic [QuoW-1:0]         quo_t;
	typedef logic [EntW-1:0]         ent_t;

	// Twice a product, sign extended to numerator width.
	function automatic num_t twice(input prod_t p);
		twice = $signed({p[ProdW-1], p, 1'b0});
	endfunction

	// 2 * (a + b) or 2 * (a - b).
	function automatic num_t twice_comb(input prod_t a, input prod_t b, input logic sub);
		logic signed [ProdW:0] t;
		t = sub ? ($signed({a[ProdW-1], a}) - $signed({b[ProdW-1], b}))
		        : ($signed({a[ProdW-1], a}) + $signed({b[ProdW-1], b}));
		twice_comb = $signed({t, 1'b0});
	endfunction

endpackage

// ===== hdl/quaternion_to_rotation_matrix_unit.sv =====
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix_unit
// Converts a raw quaternion into the nine entries of its rotation matrix.
// ----------------------------------------------------------------------------
// One beat in carries a quaternion (w, x, y, z) as four signed 16-bit integers
// of any common scale; one beat out carries the nine matrix entries in row
// major order as signed Q1.14 (16384 is 1.0), each rounded to nearest with
// ties away from zero, plus a zero_length flag on tuser. An all-zero input
// gives the identity matrix with the flag set. The unit is fully pipelined:
// it takes one beat every cycle while the output is not stalled, and each
// result passes nineteen registers on its way to the output
// (three arithmetic stages, fifteen divider stages and the output register).
// The pipeline depth is set by the restoring divider, which retires one
// quotient bit per stage in each of nine parallel lanes. Every stage has its
// own valid bit and advances when its successor is empty or advancing, so a
// stall on the output side fills bubbles first and loses nothing.
// ----------------------------------------------------------------------------
module quaternion_to_rotation_matrix_unit
	import qrm_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [63:0]  s_tdata,   // comp_w, comp_x, comp_y, comp_z (16 bits each)
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [143:0] m_tdata,   // e00, e01, e02, e10, e11, e12, e20, e21, e22
	output logic [0:0]   m_tuser    // zero_length
);

	`include "quaternion_to_rotation_matrix_unit_assert.svh"

	localparam int DivSteps = QuoW;

	// Stage 1: the ten component products.
	logic  vld_s1;
	prod_t prd_s1 [NumPrd];

	// Stage 2: sum of squares and the nine signed numerators.
	logic            vld_s2;
	logic [SumW-1:0] sum_s2;
	num_t            num_s2 [NumEnt];

	// Divider pipeline: index 0 is stage 3 (dividend set up), index k holds
	// the state after k quotient bits.
	logic            vld_sd  [DivSteps+1];
	logic            zero_sd [DivSteps+1];
	logic [DenW-1:0] den_sd  [DivSteps+1];
	logic            neg_sd  [DivSteps+1][NumEnt];
	rem_t            rem_sd  [DivSteps+1][NumEnt];
	quo_t            quo_sd  [DivSteps+1][NumEnt];

	// Output register.
	logic            vld_q;
	ent_t            ent_q [NumEnt];
	logic            zero_q;

	logic en_o, en_s1, en_s2;
	logic en_d [DivSteps+1];

	logic signed [CompW-1:0] cw, cx, cy, cz;

	// Stall chain: a stage may load when it is empty or its successor loads.
	always_comb begin
		en_o = !vld_q || m_tready;
		en_d[DivSteps] = !vld_sd[DivSteps] || en_o;
		for (int k = DivSteps - 1; k >= 0; k--) begin
			en_d[k] = !vld_sd[k] || en_d[k+1];
		end
		en_s2 = !vld_s2 || en_d[0];
		en_s1 = !vld_s1 || en_s2;
	end

	assign s_tready = en_s1;

	assign cw = $signed(s_tdata[15:0]);
	assign cx = $signed(s_tdata[31:16]);
	assign cy = $signed(s_tdata[47:32]);
	assign cz = $signed(s_tdata[63:48]);

	// ---------------- Stage 1 ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en_s1) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			prd_s1[PWW] <= cw * cw;
			prd_s1[PXX] <= cx * cx;
			prd_s1[PYY] <= cy * cy;
			prd_s1[PZZ] <= cz * cz;
			prd_s1[PXY] <= cx * cy;
			prd_s1[PWZ] <= cw * cz;
			prd_s1[PXZ] <= cx * cz;
			prd_s1[PWY] <= cw * cy;
			prd_s1[PYZ] <= cy * cz;
			prd_s1[PWX] <= cw * cx;
		end
	end

	// ---------------- Stage 2 ----------------
	logic [SumW-1:0] sum_c;
	num_t            sumx_c;
	num_t            num_c [NumEnt];

	always_comb begin
		// Squares are never negative, so their bits read as unsigned.
		sum_c = SumW'($unsigned(prd_s1[PWW])) + SumW'($unsigned(prd_s1[PXX]))
		      + SumW'($unsigned(prd_s1[PYY])) + SumW'($unsigned(prd_s1[PZZ]));
		sumx_c = $signed({1'b0, sum_c});
		num_c[0] = sumx_c - twice(prd_s1[PYY]) - twice(prd_s1[PZZ]);
		num_c[1] = twice_comb(prd_s1[PXY], prd_s1[PWZ], 1'b1);
		num_c[2] = twice_comb(prd_s1[PXZ], prd_s1[PWY], 1'b0);
		num_c[3] = twice_comb(prd_s1[PXY], prd_s1[PWZ], 1'b0);
		num_c[4] = sumx_c - twice(prd_s1[PXX]) - twice(prd_s1[PZZ]);
		num_c[5] = twice_comb(prd_s1[PYZ], prd_s1[PWX], 1'b1);
		num_c[6] = twice_comb(prd_s1[PXZ], prd_s1[PWY], 1'b1);
		num_c[7] = twice_comb(prd_s1[PYZ], prd_s1[PWX], 1'b0);
		num_c[8] = sumx_c - twice(prd_s1[PXX]) - twice(prd_s1[PYY]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			sum_s2 <= sum_c;
			for (int i = 0; i < NumEnt; i++) begin
				num_s2[i] <= num_c[i];
			end
		end
	end

	// ---------------- Stage 3: dividend setup ----------------
	// Entry = floor((2 * 16384 * |N| + S) / (2 * S)), then the sign of N.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sd[0] <= 1'b0;
		end else if (en_d[0]) begin
			vld_sd[0] <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		logic [MagW-1:0] mag;
		if (en_d[0]) begin
			zero_sd[0] <= (sum_s2 == '0);
			den_sd[0]  <= {sum_s2, 1'b0};
			for (int i = 0; i < NumEnt; i++) begin
				mag = num_s2[i][NumW-1] ? MagW'(-num_s2[i]) : MagW'(num_s2[i]);
				neg_sd[0][i] <= num_s2[i][NumW-1];
				rem_sd[0][i] <= {mag, {FracW{1'b0}}} + RemW'(sum_s2);
				quo_sd[0][i] <= '0;
			end
		end
	end

	// ---------------- Divider stages ----------------
	for (genvar k = 1; k <= DivSteps; k++) begin : g_div
		localparam int Sh = DivSteps - k;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sd[k] <= 1'b0;
			end else if (en_d[k]) begin
				vld_sd[k] <= vld_sd[k-1];
			end
		end

		always_ff @(posedge clk) begin
			rem_t trial;
			if (en_d[k]) begin
				trial = RemW'(den_sd[k-1]) << Sh;
				zero_sd[k] <= zero_sd[k-1];
				den_sd[k]  <= den_sd[k-1];
				for (int i = 0; i < NumEnt; i++) begin
					neg_sd[k][i] <= neg_sd[k-1][i];
					if (rem_sd[k-1][i] >= trial) begin
						rem_sd[k][i] <= rem_sd[k-1][i] - trial;
						quo_sd[k][i] <= {quo_sd[k-1][i][QuoW-2:0], 1'b1};
					end else begin
						rem_sd[k][i] <= rem_sd[k-1][i];
						quo_sd[k][i] <= {quo_sd[k-1][i][QuoW-2:0], 1'b0};
					end
				end
			end
		end
	end

	// ---------------- Output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en_o) begin
			vld_q <= vld_sd[DivSteps];
		end
	end

	always_ff @(posedge clk) begin
		ent_t mag_e;
		if (en_o) begin
			zero_q <= zero_sd[DivSteps];
			for (int i = 0; i < NumEnt; i++) begin
				mag_e = {1'b0, quo_sd[DivSteps][i]};
				if (zero_sd[DivSteps]) begin
					// Identity: ones on the diagonal.
					ent_q[i] <= (i % 4 == 0) ? OneQ14 : '0;
				end else begin
					ent_q[i] <= neg_sd[DivSteps][i] ? -mag_e : mag_e;
				end
			end
		end
	end

	assign m_tvalid = vld_q;
	assign m_tuser  = zero_q;
	for (genvar i = 0; i < NumEnt; i++) begin : g_out
		assign m_tdata[i*EntW +: EntW] = ent_q[i];
	end

	// ---------------- Assertions ----------------
	// An accepting consumer always lets the whole pipeline advance.
	`QRM_ASSERT_SAME(a_ready_follows, m_tready, s_tready)
	// A zero-length result carries the identity matrix.
	`QRM_ASSERT_SAME(a_zero_identity, m_tvalid && m_tuser[0],
		m_tdata[15:0] == OneQ14 && m_tdata[79:64] == OneQ14
		&& m_tdata[143:128] == OneQ14 && m_tdata[31:16] == '0)
	// Entry e00 never exceeds one in magnitude.
	`QRM_ASSERT_SAME(a_e00_range, m_tvalid,
		$signed(m_tdata[15:0]) <= 16384 && $signed(m_tdata[15:0]) >= -16384)
	// An accepted beat marks the first stage valid.
	`QRM_ASSERT_NEXT(a_s1_loads, s_tvalid && s_tready, vld_s1)

endmodule

// ===== bench/qrm_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// qrm_checker
// Watches both channels of the quaternion unit, predicts each matrix from the
// accepted quaternion and compares it with the beat that comes out.
// ----------------------------------------------------------------------------
module qrm_checker
	import qrm_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [63:0]  s_tdata,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [143:0] m_tdata,
	input  logic [0:0]   m_tuser,
	output int           errors,
	output int           pending
);

	typedef struct packed {
		logic         zero_length;
		logic [143:0] entries;
	} matrix_t;

	matrix_t matrix_q[$];

	// Rounded 16384 * num / den, ties away from zero.
	function automatic logic [15:0] q14_ratio(input longint num, input longint den);
		longint mag;
		longint q;
		mag = (num < 0) ? -num : num;
		q = (mag * 32768 + den) / (2 * den);
		if (num < 0)
			q = -q;
		return q[15:0];
	endfunction

	function automatic matrix_t rotation_of(input logic [63:0] quat);
		longint w, x, y, z, s;
		longint n[9];
		matrix_t m;
		w = $signed(quat[15:0]);
		x = $signed(quat[31:16]);
		y = $signed(quat[47:32]);
		z = $signed(quat[63:48]);
		s = w*w + x*x + y*y + z*z;
		m.zero_length = (s == 0);
		if (s == 0) begin
			m.entries = '0;
			m.entries[15:0] = OneQ14;
			m.entries[79:64] = OneQ14;
			m.entries[143:128] = OneQ14;
			return m;
		end
		n[0] = s - 2*y*y - 2*z*z;
		n[1] = 2*(x*y - w*z);
		n[2] = 2*(x*z + w*y);
		n[3] = 2*(x*y + w*z);
		n[4] = s - 2*x*x - 2*z*z;
		n[5] = 2*(y*z - w*x);
		n[6] = 2*(x*z - w*y);
		n[7] = 2*(y*z + w*x);
		n[8] = s - 2*x*x - 2*y*y;
		for (int i = 0; i < 9; i++)
			m.entries[i*16 +: 16] = q14_ratio(n[i], s);
		return m;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		matrix_t want;
		int bad;
		bad = 0;
		if (!arst_n) begin
			errors  <= 0;
			pending <= 0;
		end else begin
			if (s_tvalid && s_tready)
				matrix_q.push_back(rotation_of(s_tdata));
			if (m_tvalid && m_tready) begin
				if (matrix_q.size() == 0) begin
					$display("%0t: expected no result, actual %h", $time, m_tdata);
					bad = bad + 1;
				end else begin
					want = matrix_q.pop_front();
					for (int i = 0; i < 9; i++)
						if (want.entries[i*16 +: 16] !== m_tdata[i*16 +: 16]) begin
							$display("%0t: entry %0d expected %0d actual %0d", $time, i,
								$signed(want.entries[i*16 +: 16]),
								$signed(m_tdata[i*16 +: 16]));
							bad = bad + 1;
						end
					if (want.zero_length !== m_tuser[0]) begin
						$display("%0t: zero_length expected %b actual %b", $time,
							want.zero_length, m_tuser[0]);
						bad = bad + 1;
					end
				end
			end
			errors  <= errors + bad;
			pending <= matrix_q.size();
		end
	end

endmodule

// ===== bench/tb_quaternion_to_rotation_matrix_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_quaternion_to_rotation_matrix_unit
// Drives directed and random quaternions into the unit with random gaps and
// output stalls; the checker predicts and compares every matrix beat.
// ----------------------------------------------------------------------------
module tb_quaternion_to_rotation_matrix_unit;

	localparam int RandomBeats = 1250;
	localparam int CycleLimit  = 200000;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [63:0]  s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [143:0] m_tdata;
	logic [0:0]   m_tuser;
	int           errors;
	int           pending;
	int           cycles = 0;
	logic         calm = 1'b0;  // no idling on either side while set

	always #4 clk = ~clk;

	quaternion_to_rotation_matrix_unit u_top (.*);

	qrm_checker u_checker (.*);

	// Output side stalls at random with a probability of 0.16, except in the calm stretch.
	always @(posedge clk)
		m_tready <= calm || ($urandom_range(99) >= 16);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Offers one beat, with a random gap first, and holds it until accepted.
	task automatic send_quat(input logic [15:0] w, x, y, z);
		while (!calm && $urandom_range(99) < 16) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {z, y, x, w};
		do @(posedge clk); while (!s_tready);
	endtask

	function automatic logic [15:0] rand_comp();
		case ($urandom_range(3))
			0: return 16'($urandom_range(15)) - 16'd8;
			1: return {$urandom_range(1) ? 16'h8000 : 16'h7fff};
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// Zero length, unit axes and extremes.
		send_quat(16'd0, 16'd0, 16'd0, 16'd0);
		send_quat(16'd1, 16'd0, 16'd0, 16'd0);
		send_quat(16'd0, 16'd1, 16'd0, 16'd0);
		send_quat(16'd0, 16'd0, 16'd1, 16'd0);
		send_quat(16'd0, 16'd0, 16'd0, 16'd1);
		send_quat(16'h8000, 16'd0, 16'd0, 16'd0);
		send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
		send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
		send_quat(16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
		send_quat(16'hffff, 16'hffff, 16'hffff, 16'hffff);
		send_quat(16'd1, 16'd1, 16'd1, 16'd0);
		send_quat(16'd1, 16'd2, 16'd3, 16'd4);
		send_quat(16'h8000, 16'h7fff, 16'd1, 16'hffff);
		send_quat(16'd0, 16'h5555, 16'haaaa, 16'd0);
		send_quat(16'd3, 16'd0, 16'd0, 16'hfffd);
		for (int i = 0; i < RandomBeats; i++) begin
			calm = (i >= 400 && i < 550);
			if ($urandom_range(49) == 0)
				send_quat(16'd0, 16'd0, 16'd0, 16'd0);
			else
				send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
		end
		s_tvalid <= 1'b0;
		calm = 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
